// ===== hw/rtl/eadsr_pkg.sv =====
// ----------------------------------------------------------------------------
// eadsr_pkg: shared types and constants of the exponential ADSR envelope
// Field widths, gain and step formats, codes and control structs.
// ----------------------------------------------------------------------------
package eadsr_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 40;
  localparam int GAIN_BITS      = GAIN_FRAC_BITS + 2;
  localparam int MUL_BITS       = 32;
  localparam int PROD_BITS      = 2 * MUL_BITS;
  localparam int GAIN_HI_BITS   = GAIN_BITS - MUL_BITS;
  localparam int STEP_BITS      = 32;
  localparam int STEP_FRAC_BITS = 30;
  localparam int LEVEL_BITS     = 41;
  localparam int CFG_IDX_BITS   = 3;
  localparam int PHASE_BITS     = 3;

  localparam logic [STEP_BITS-1:0]  ATTACK_RESET  = 32'd1074205489;
  localparam logic [STEP_BITS-1:0]  DECAY_RESET   = 32'd1073690316;
  localparam logic [STEP_BITS-1:0]  RELEASE_RESET = 32'd1073278358;
  localparam logic [LEVEL_BITS-1:0] SUSTAIN_RESET = 41'd109951162778;
  localparam logic [LEVEL_BITS-1:0] FLOOR_RESET   = 41'd1100;

  localparam logic [GAIN_BITS-1:0] GAIN_MAX   = '1;
  localparam logic [GAIN_BITS-1:0] GAIN_UNITY = GAIN_BITS'(1) << GAIN_FRAC_BITS;
  localparam logic [STEP_BITS-1:0] STEP_UNITY = STEP_BITS'(1) << STEP_FRAC_BITS;

  typedef enum logic [1:0] {
    KIND_SAMPLE   = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_NOTE_OFF = 2'd2
  } kind_t;

  typedef enum logic [PHASE_BITS-1:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ATTACK  = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_RELEASE = 3'd2,
    CFG_SUSTAIN = 3'd3,
    CFG_FLOOR   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MUL_G0S,
    MUL_G1S,
    MUL_MG0,
    MUL_MG1
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_GAIN,
    ST_SCL_LO,
    ST_SCL_HI,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]                    kind;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [PHASE_BITS-1:0]         phase_now;
  } out_item_t;

  typedef struct packed {
    logic [STEP_BITS-1:0]  attack_step;
    logic [STEP_BITS-1:0]  decay_step;
    logic [STEP_BITS-1:0]  release_step;
    logic [LEVEL_BITS-1:0] sustain_level;
    logic [LEVEL_BITS-1:0] floor_level;
  } cfg_regs_t;

  typedef struct packed {
    logic     load_sample;
    logic     note_on;
    logic     note_off;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     save_lo;
    logic     gain_upd;
    logic     finish;
  } cmd_t;

endpackage

// ===== hw/rtl/exponential_adsr_envelope_unit.sv =====
// ----------------------------------------------------------------------------
// exponential_adsr_envelope_unit: dB-linear ADSR envelope applied to samples
// Sample item: stepped through MUL_LO, MUL_HI, GAIN, SCL_LO, SCL_HI and DONE
// on the single 32x32 multiplier doing four partial products; the next item
// is taken back in idle. Note-on and note-off items give no result.
// Synchronous reset: phase off, gain and step zero, registers to defaults.
// ----------------------------------------------------------------------------
module exponential_adsr_envelope_unit import eadsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [LEVEL_BITS-1:0]   cfg_data
);

  cfg_regs_t regs;
  cmd_t      cmd;

  assign cfg_ready = 1'b1;

  eadsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  eadsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  eadsr_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .regs     (regs),
    .out_data (out_data)
  );

endmodule

// ===== hw/rtl/eadsr_cfg.sv =====
// ----------------------------------------------------------------------------
// eadsr_cfg: configuration register file
// Step factors and levels, written through the configuration channel.
// ----------------------------------------------------------------------------
module eadsr_cfg import eadsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [LEVEL_BITS-1:0]   cfg_data,
  output cfg_regs_t               regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.attack_step   <= ATTACK_RESET;
      regs.decay_step    <= DECAY_RESET;
      regs.release_step  <= RELEASE_RESET;
      regs.sustain_level <= SUSTAIN_RESET;
      regs.floor_level   <= FLOOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATTACK:  regs.attack_step   <= cfg_data[STEP_BITS-1:0];
        CFG_DECAY:   regs.decay_step    <= cfg_data[STEP_BITS-1:0];
        CFG_RELEASE: regs.release_step  <= cfg_data[STEP_BITS-1:0];
        CFG_SUSTAIN: regs.sustain_level <= cfg_data;
        CFG_FLOOR:   regs.floor_level   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/eadsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// eadsr_ctrl: envelope sequencer
// Steps one sample item through the shared multiplier and owns out_valid.
// ----------------------------------------------------------------------------
module eadsr_ctrl import eadsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_kind,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output cmd_t       cmd
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul_sel = MUL_G0S;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_kind)
            KIND_SAMPLE: begin
              cmd.load_sample = 1'b1;
              state_next      = ST_MUL_LO;
            end
            KIND_NOTE_ON:  cmd.note_on  = 1'b1;
            KIND_NOTE_OFF: cmd.note_off = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MUL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_G0S;
        state_next  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_G1S;
        cmd.save_lo = 1'b1;
        state_next  = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.gain_upd = 1'b1;
        state_next   = ST_SCL_LO;
      end
      ST_SCL_LO: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MG0;
        state_next  = ST_SCL_HI;
      end
      ST_SCL_HI: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MG1;
        cmd.save_lo = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid_next = cmd.finish | (out_valid & ~out_ready);

endmodule

// ===== hw/rtl/eadsr_dp.sv =====
// ----------------------------------------------------------------------------
// eadsr_dp: envelope datapath
// Gain, phase and step state, one shared 32x32 multiplier, output register.
// ----------------------------------------------------------------------------
module eadsr_dp import eadsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  in_item_t  in_data,
  input  cfg_regs_t regs,
  output out_item_t out_data
);

  localparam int MID_BITS = GAIN_HI_BITS + STEP_BITS;
  localparam int R_BITS   = MID_BITS + 3;
  localparam int HI_BITS  = SAMPLE_BITS + GAIN_HI_BITS;
  localparam int SS_BITS  = HI_BITS + 1;
  localparam int Q_SHIFT  = GAIN_FRAC_BITS - MUL_BITS;
  localparam int Q_BITS   = SS_BITS - Q_SHIFT;
  localparam logic [Q_BITS-1:0] LIM_POS = Q_BITS'((64'(1) << (SAMPLE_BITS - 1)) - 64'(1));
  localparam logic [Q_BITS-1:0] LIM_NEG = Q_BITS'(64'(1) << (SAMPLE_BITS - 1));

  phase_t                 phase;
  logic [GAIN_BITS-1:0]   gain;
  logic [STEP_BITS-1:0]   step;
  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [PROD_BITS-1:0]   prod;
  logic [PROD_BITS-1:0]   lo_reg;

  logic [MUL_BITS-1:0]    mul_a, mul_b;
  logic [R_BITS-1:0]      gsum;
  logic [GAIN_BITS-1:0]   gain_new;
  logic [SS_BITS-1:0]     ssum;
  logic [Q_BITS-1:0]      q, lim;
  logic [SAMPLE_BITS-1:0] y;
  logic [SAMPLE_BITS-1:0] raw;
  phase_t                 ph_fin;
  logic [GAIN_BITS-1:0]   gain_fin;
  logic [STEP_BITS-1:0]   step_fin;

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_G0S: begin
        mul_a = gain[MUL_BITS-1:0];
        mul_b = step;
      end
      MUL_G1S: begin
        mul_a = MUL_BITS'(gain[GAIN_BITS-1:MUL_BITS]);
        mul_b = step;
      end
      MUL_MG0: begin
        mul_a = MUL_BITS'(mag);
        mul_b = gain[MUL_BITS-1:0];
      end
      MUL_MG1: begin
        mul_a = MUL_BITS'(mag);
        mul_b = MUL_BITS'(gain[GAIN_BITS-1:MUL_BITS]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // gain * step >> 30 from the high and low partial products, saturated
  always_comb begin
    gsum = R_BITS'({prod[MID_BITS-1:0], 2'b00})
         + R_BITS'(lo_reg[PROD_BITS-1:STEP_FRAC_BITS]);
    gain_new = (gsum[R_BITS-1:GAIN_BITS] != '0) ? GAIN_MAX : gsum[GAIN_BITS-1:0];
  end

  // magnitude * gain >> GAIN_FRAC_BITS, saturated to the signed range
  always_comb begin
    ssum = SS_BITS'(prod[HI_BITS-1:0]) + SS_BITS'(lo_reg[PROD_BITS-1:MUL_BITS]);
    q    = ssum[SS_BITS-1:Q_SHIFT];
    lim  = neg ? LIM_NEG : LIM_POS;
    if (q > lim) q = lim;
    y = neg ? (SAMPLE_BITS'(0) - q[SAMPLE_BITS-1:0]) : q[SAMPLE_BITS-1:0];
  end

  always_comb begin
    ph_fin   = phase;
    gain_fin = gain;
    step_fin = step;
    if (ph_fin == PH_RELEASE && gain_fin < GAIN_BITS'(regs.floor_level)) begin
      ph_fin   = PH_OFF;
      gain_fin = '0;
    end
    if (ph_fin == PH_ATTACK && gain_fin >= GAIN_UNITY) begin
      ph_fin   = PH_DECAY;
      step_fin = regs.decay_step;
    end
    if (ph_fin == PH_DECAY && gain_fin < GAIN_BITS'(regs.sustain_level)) begin
      ph_fin   = PH_SUSTAIN;
      step_fin = STEP_UNITY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_OFF;
      gain  <= '0;
      step  <= '0;
    end else begin
      priority if (cmd.note_on) begin
        phase <= PH_ATTACK;
        gain  <= GAIN_BITS'(regs.floor_level);
        step  <= regs.attack_step;
      end else if (cmd.note_off) begin
        phase <= PH_RELEASE;
        step  <= regs.release_step;
      end else if (cmd.gain_upd) begin
        gain <= gain_new;
      end else if (cmd.finish) begin
        phase <= ph_fin;
        gain  <= gain_fin;
        step  <= step_fin;
      end
    end
  end

  assign raw = in_data.sample_in;

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      neg <= raw[SAMPLE_BITS-1];
      mag <= raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
    end
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.save_lo) lo_reg <= prod;
    if (cmd.finish) begin
      out_data.sample_out <= y;
      out_data.phase_now  <= ph_fin;
    end
  end

endmodule

// ===== dv/exponential_adsr_envelope_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_adsr_envelope_unit_test: self-checking bench for the envelope unit
// Sends note-on, note-off and sample items over valid/ready and tracks the
// envelope in a local model. Each returned sample and phase is checked in order
// across register settings, idle and stall patterns and a long output hold-off.
// ----------------------------------------------------------------------------
module exponential_adsr_envelope_unit_test;
  import eadsr_pkg::*;

  localparam logic [1:0]              KIND_RESERVED   = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED      = 3'd7;
  localparam logic [LEVEL_BITS-1:0]   LEVEL_TOP       = 41'd1 << 40;
  localparam int                      ITEMS_PER_PHASE = 400;
  localparam int                      HOLD_CYCLES     = 300;
  localparam int                      SETTLE_CYCLES   = 12;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  in_item_t                in_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  out_item_t               out_data;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [LEVEL_BITS-1:0]   cfg_data = '0;

  // envelope model state
  cfg_regs_t               regs_now;
  phase_t                  env_phase;
  logic [GAIN_BITS-1:0]    env_gain;
  logic [STEP_BITS-1:0]    env_step;
  out_item_t               due_samples[$];
  out_item_t               head;

  int                      mismatches = 0;
  int                      send_idle_pct = 0;
  int                      recv_stall_pct = 0;
  logic                    holding = 1'b0;
  event                    hold_evt;

  exponential_adsr_envelope_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // long output hold-off, counted here
  initial begin
    forever begin
      @(hold_evt);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_samples.size() == 0) begin
        report_mismatch("result with no sample item pending");
      end else begin
        head = due_samples.pop_front();
        if (out_data.sample_out !== head.sample_out)
          report_mismatch($sformatf("sample_out %0d, want %0d",
                                    out_data.sample_out, head.sample_out));
        if (out_data.phase_now !== head.phase_now)
          report_mismatch($sformatf("phase_now %0d, want %0d",
                                    out_data.phase_now, head.phase_now));
      end
    end
  end

  task automatic advance_envelope(input in_item_t item);
    logic [GAIN_BITS+STEP_BITS-1:0]   gain_prod;
    logic [SAMPLE_BITS-1:0]           mag;
    logic [SAMPLE_BITS+GAIN_BITS-1:0] scale_prod;
    logic [SAMPLE_BITS+1:0]           quot;
    logic [SAMPLE_BITS+1:0]           lim;
    logic                             neg;
    out_item_t                        res;
    case (item.kind)
      KIND_NOTE_ON: begin
        env_phase = PH_ATTACK;
        env_gain  = GAIN_BITS'(regs_now.floor_level);
        env_step  = regs_now.attack_step;
      end
      KIND_NOTE_OFF: begin
        env_phase = PH_RELEASE;
        env_step  = regs_now.release_step;
      end
      KIND_SAMPLE: begin
        gain_prod = env_gain * env_step;
        if ((gain_prod >> STEP_FRAC_BITS) > GAIN_MAX) env_gain = GAIN_MAX;
        else env_gain = gain_prod[STEP_FRAC_BITS +: GAIN_BITS];
        neg = item.sample_in[SAMPLE_BITS-1];
        mag = neg ? ~item.sample_in + 1'b1 : item.sample_in;
        scale_prod = mag * env_gain;
        quot = scale_prod >> GAIN_FRAC_BITS;
        lim = neg ? 26'd1 << (SAMPLE_BITS - 1) : (26'd1 << (SAMPLE_BITS - 1)) - 1'b1;
        if (quot > lim) quot = lim;
        res.sample_out = neg ? ~quot[SAMPLE_BITS-1:0] + 1'b1 : quot[SAMPLE_BITS-1:0];
        if (env_phase == PH_RELEASE && env_gain < regs_now.floor_level) begin
          env_phase = PH_OFF;
          env_gain  = '0;
        end
        if (env_phase == PH_ATTACK && env_gain >= GAIN_UNITY) begin
          env_phase = PH_DECAY;
          env_step  = regs_now.decay_step;
        end
        if (env_phase == PH_DECAY && env_gain < regs_now.sustain_level) begin
          env_phase = PH_SUSTAIN;
          env_step  = STEP_UNITY;
        end
        res.phase_now = env_phase;
        due_samples.push_back(res);
      end
      default: ;
    endcase
  endtask

  // valid stays high between back-to-back items; dropped only for a gap
  task automatic send_item(input logic [1:0] kind, input logic [SAMPLE_BITS-1:0] sample);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind, sample};
    do @(posedge clk); while (!in_ready);
    advance_envelope(in_data);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [LEVEL_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ATTACK:  regs_now.attack_step   = value[STEP_BITS-1:0];
      CFG_DECAY:   regs_now.decay_step    = value[STEP_BITS-1:0];
      CFG_RELEASE: regs_now.release_step  = value[STEP_BITS-1:0];
      CFG_SUSTAIN: regs_now.sustain_level = value;
      CFG_FLOOR:   regs_now.floor_level   = value;
      default: ;
    endcase
  endtask

  // upper bits of step writes carry junk, the unit keeps the low 32
  task automatic load_registers(input cfg_regs_t regs);
    write_reg(CFG_ATTACK, {9'($urandom), regs.attack_step});
    write_reg(CFG_DECAY, {9'($urandom), regs.decay_step});
    write_reg(CFG_RELEASE, {9'($urandom), regs.release_step});
    write_reg(CFG_SUSTAIN, regs.sustain_level);
    write_reg(CFG_FLOOR, regs.floor_level);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_item(KIND_SAMPLE, 24'h000400);
    send_item(KIND_RESERVED, 24'h555555);
    send_item(KIND_NOTE_OFF, 24'hAAAAAA);
    send_item(KIND_SAMPLE, 24'h800000);
    send_item(KIND_NOTE_ON, '0);
    send_item(KIND_SAMPLE, 24'h7FFFFF);
    send_item(KIND_SAMPLE, 24'hFFFFFF);
    send_item(KIND_NOTE_ON, 24'h123456);
    send_item(KIND_SAMPLE, 24'h800000);
  endtask

  task automatic test_level_extremes();
    cfg_regs_t regs;
    // max steps, unity floor: gain saturates, zero release drops to off
    wait_results_done();
    regs = '{attack_step: '1, decay_step: '1, release_step: '0,
             sustain_level: LEVEL_TOP, floor_level: LEVEL_TOP};
    write_reg(CFG_UNUSED, 41'($urandom));
    load_registers(regs);
    send_item(KIND_NOTE_ON, '0);
    send_item(KIND_SAMPLE, 24'h7FFFFF);
    send_item(KIND_SAMPLE, 24'h800000);
    send_item(KIND_NOTE_OFF, '0);
    send_item(KIND_SAMPLE, 24'h000123);
    send_item(KIND_SAMPLE, 24'hFFFFFB);
    // zero attack never ends, zero floor keeps release alive
    wait_results_done();
    regs = '{attack_step: '0, decay_step: '0, release_step: STEP_UNITY,
             sustain_level: '0, floor_level: '0};
    load_registers(regs);
    send_item(KIND_NOTE_ON, '1);
    send_item(KIND_SAMPLE, pick_sample());
    send_item(KIND_NOTE_OFF, '0);
    send_item(KIND_SAMPLE, 24'h7FFFFF);
    send_item(KIND_SAMPLE, 24'h800000);
    // unity attack from unity floor: decay, then sustain, then restarts
    wait_results_done();
    regs = '{attack_step: STEP_UNITY, decay_step: STEP_UNITY - 1'b1, release_step: '1,
             sustain_level: LEVEL_TOP, floor_level: LEVEL_TOP};
    load_registers(regs);
    send_item(KIND_NOTE_ON, '0);
    send_item(KIND_SAMPLE, 24'h7FFFFF);
    send_item(KIND_SAMPLE, 24'h800000);
    send_item(KIND_SAMPLE, 24'hFFFC18);
    send_item(KIND_NOTE_ON, '0);
    send_item(KIND_NOTE_OFF, '0);
    send_item(KIND_SAMPLE, 24'h7FFFFF);
  endtask

  task automatic test_random_notes();
    cfg_regs_t  regs;
    int         sent;
    int         pick;
    int         n;
    logic [1:0] kind;
    for (int p = 0; p < 4; p++) begin
      wait_results_done();
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (p < 3) begin
        regs.attack_step   = $urandom_range(32'hFFFF_FFFF, 32'h8000_0000);
        regs.decay_step    = $urandom_range(32'h3FFF_FFFF, 32'h2000_0000);
        regs.release_step  = $urandom_range(32'h3FFF_FFFF, 32'h1000_0000);
        regs.sustain_level = 41'($urandom) << $urandom_range(8, 4);
        regs.floor_level   = 41'($urandom_range(32'hFFFF_FFFF, 1)) << $urandom_range(8);
      end else begin
        regs.attack_step   = $urandom;
        regs.decay_step    = $urandom;
        regs.release_step  = $urandom;
        regs.sustain_level = 41'({$urandom, $urandom}) % (LEVEL_TOP + 1'b1);
        regs.floor_level   = 41'({$urandom, $urandom}) % (LEVEL_TOP + 1'b1);
      end
      load_registers(regs);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          kind = 2'($urandom_range(3));
          send_item(kind, pick_sample());
          if (kind != KIND_RESERVED) sent++;
        end else if (pick < 20) begin
          send_item(pick < 15 ? KIND_NOTE_OFF : KIND_NOTE_ON, pick_sample());
          n = $urandom_range(8, 1);
          repeat (n) send_item(KIND_SAMPLE, pick_sample());
          sent += n + 1;
        end else begin
          send_item(KIND_NOTE_ON, pick_sample());
          n = $urandom_range(60, 5);
          repeat (n) send_item(KIND_SAMPLE, pick_sample());
          sent += n + 2;
          send_item(KIND_NOTE_OFF, pick_sample());
          n = $urandom_range(40, 3);
          repeat (n) send_item(KIND_SAMPLE, pick_sample());
          sent += n;
        end
      end
    end
  endtask

  // output held off while items keep coming, then drain
  task automatic test_output_hold();
    wait_results_done();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    -> hold_evt;
    send_item(KIND_NOTE_ON, pick_sample());
    repeat (38) send_item(KIND_SAMPLE, pick_sample());
    send_item(KIND_NOTE_OFF, pick_sample());
    repeat (10) send_item(KIND_SAMPLE, pick_sample());
    wait_results_done();
  endtask

  initial begin
    regs_now = '{attack_step: ATTACK_RESET, decay_step: DECAY_RESET,
                 release_step: RELEASE_RESET, sustain_level: SUSTAIN_RESET,
                 floor_level: FLOOR_RESET};
    env_phase = PH_OFF;
    env_gain  = '0;
    env_step  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_level_extremes();
    test_random_notes();
    test_output_hold();
    wait_results_done();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== exponential_adsr_envelope_unit.f =====
hw/rtl/eadsr_pkg.sv
hw/rtl/eadsr_cfg.sv
hw/rtl/eadsr_ctrl.sv
hw/rtl/eadsr_dp.sv
hw/rtl/exponential_adsr_envelope_unit.sv
dv/exponential_adsr_envelope_unit_test.sv
